// ----- hdl/ffba_pkg.sv -----
// ffba_pkg: shared types, codes and sizes for the first-fit block allocator
// no dependencies; imported by every module of the block

package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0] HEADER_ADD     = 32'(HEADER_BYTES);
  localparam logic [31:0] HEAP_BASE_RST  = 32'd0;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

  // request actions
  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_RESIZE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_HEAP    = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  // configuration register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_address;
    logic [31:0] copy_source;
    logic [31:0] copy_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  // which fields the result carries
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DATA,
    OUT_KEEP,
    OUT_MOVE
  } out_kind_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_en;
    logic       scan_fit;
    logic       save_old;
    logic       wr_reuse;
    logic       wr_append;
    logic       wr_free_hit;
    logic       wr_free_old;
    logic       finish;
    out_kind_t  kind;
    logic [1:0] status;
  } ffba_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic fits_old;
    logic no_heap;
    logic table_full;
  } ffba_sts_t;

  typedef struct packed {
    logic        base_wr;
    logic [31:0] base;
    logic [31:0] limit;
  } ffba_cfg_t;

endpackage

// ----- hdl/ffba_dpath.sv -----
// ffba_dpath: block table memory, scan pointer, heap top and result register
// depends on ffba_pkg; driven by ffba_ctrl through ffba_cmd_t

module ffba_dpath
  import ffba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_req,
  input  ffba_cfg_t cfg,
  input  ffba_cmd_t cmd,
  output ffba_sts_t sts,
  output logic      out_valid,
  output out_item_t out_res
);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;

  in_item_t         req_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      heap_top_r;
  logic [33:0]      end_r;
  logic [31:0]      data_r;
  entry_t           old_q;
  logic [IDX_W-1:0] old_idx_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic             issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             match_addr;
  logic             match_fit;
  out_item_t        out_nxt;

  assign issue      = cmd.scan_en && !cmd.scan_start && (scan_idx_r < count_r);
  assign match_addr = (rd_q.start + HEADER_ADD) == req_r.block_address;
  assign match_fit  = rd_q.free && (rd_q.size >= req_r.request_size);

  assign sts.hit        = rd_vld_r && (cmd.scan_fit ? match_fit : match_addr);
  assign sts.exhausted  = !rd_vld_r && (scan_idx_r >= count_r);
  assign sts.fits_old   = rd_q.size >= req_r.request_size;
  assign sts.no_heap    = end_r > {2'b00, cfg.limit};
  assign sts.table_full = count_r >= CNT_W'(MAX_BLOCKS);

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_idx_r;
    wr_data = '{start: rd_q.start, size: rd_q.size, free: 1'b1};
    priority if (cmd.wr_append) begin
      wr_addr = count_r[IDX_W-1:0];
      wr_data = '{start: heap_top_r, size: req_r.request_size, free: 1'b0};
    end else if (cmd.wr_reuse) begin
      wr_data.free = 1'b0;
    end else if (cmd.wr_free_hit) begin
      wr_data.free = 1'b1;
    end else if (cmd.wr_free_old) begin
      wr_addr = old_idx_r;
      wr_data = '{start: old_q.start, size: old_q.size, free: 1'b1};
    end else begin
      wr_en = 1'b0;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    out_nxt = '{status: cmd.status, data_address: 32'd0, copy_source: 32'd0,
                copy_length: 32'd0};
    unique case (cmd.kind)
      OUT_NONE: ;
      OUT_DATA: out_nxt.data_address = data_r;
      OUT_KEEP: out_nxt.data_address = req_r.block_address;
      OUT_MOVE: begin
        out_nxt.data_address = data_r;
        out_nxt.copy_source  = req_r.block_address;
        out_nxt.copy_length  = old_q.size;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      heap_top_r  <= HEAP_BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        rd_vld_r   <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_vld_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
      end
      if (cmd.wr_append) begin
        count_r    <= count_r + CNT_W'(1);
        heap_top_r <= end_r[31:0];
      end else if (cfg.base_wr && (count_r == '0)) begin
        heap_top_r <= cfg.base;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (issue) begin
      rd_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    end_r <= {2'b00, heap_top_r} + 34'(HEADER_BYTES) + {2'b00, req_r.request_size};
    if (cmd.wr_reuse) begin
      data_r <= rd_q.start + HEADER_ADD;
    end else if (cmd.wr_append) begin
      data_r <= heap_top_r + HEADER_ADD;
    end
    if (cmd.save_old) begin
      old_q     <= rd_q;
      old_idx_r <= rd_idx_r;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ----- hdl/ffba_ctrl.sv -----
// ffba_ctrl: request sequencer for the allocator (lookup, fit scan, growth)
// depends on ffba_pkg; commands ffba_dpath and reads its status

module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  logic       addr_zero,
  input  ffba_sts_t  sts,
  output ffba_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FIT,
    S_GROW,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] act_r, act_nxt;
  logic       moving_r, moving_nxt;

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    moving_nxt = moving_r;
    cmd        = '0;
    cmd.kind   = OUT_NONE;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          act_nxt    = action;
          moving_nxt = 1'b0;
          priority if (action == ACT_ALLOC || (action == ACT_RESIZE && addr_zero)) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_FIT;
          end else if ((action == ACT_FREE || action == ACT_RESIZE) && !addr_zero) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_LOOKUP;
          end else begin
            // free of address zero or an unused action code
            cmd.finish = 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        cmd.scan_en = 1'b1;
        if (sts.hit) begin
          if (act_r == ACT_FREE) begin
            cmd.wr_free_hit = 1'b1;
            cmd.finish      = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.save_old = 1'b1;
            if (sts.fits_old) begin
              cmd.finish = 1'b1;
              cmd.kind   = OUT_KEEP;
              state_nxt  = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              moving_nxt     = 1'b1;
              state_nxt      = S_FIT;
            end
          end
        end else if (sts.exhausted) begin
          cmd.finish = 1'b1;
          cmd.status = ST_UNKNOWN;
          state_nxt  = S_IDLE;
        end
      end
      S_FIT: begin
        cmd.scan_en  = 1'b1;
        cmd.scan_fit = 1'b1;
        if (sts.hit) begin
          cmd.wr_reuse = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.exhausted) begin
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        // heap limit is checked before the table size
        priority if (sts.no_heap) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NO_HEAP;
          state_nxt  = S_IDLE;
        end else if (sts.table_full) begin
          cmd.finish = 1'b1;
          cmd.status = ST_TABLE_FULL;
          state_nxt  = S_IDLE;
        end else begin
          cmd.wr_append = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        if (moving_r) begin
          cmd.wr_free_old = 1'b1;
          cmd.kind        = OUT_MOVE;
        end else begin
          cmd.kind = OUT_DATA;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      act_r    <= ACT_ALLOC;
      moving_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: n = entries in use, up to 64; a scan walks the n table entries.
// free of address zero answers without a scan; free scans for the address (unknown address);
// allocate reuses the first free fit or appends; a moving resize runs a lookup scan, then a fit scan.
// each scan reads one table entry per cycle through the single memory read port.
// one request at a time; a new start is taken while the last result is shown.
// synchronous active-low reset empties the table and restores the registers.

module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_req,
  output logic        out_valid,
  output out_item_t   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] heap_base_r;
  logic [31:0] heap_limit_r;
  logic        reg_wr;
  logic        reg_sel;
  ffba_cfg_t   cfg;
  ffba_cmd_t   cmd;
  ffba_sts_t   sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= HEAP_BASE_RST;
      heap_limit_r <= HEAP_LIMIT_RST;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_HEAP_BASE:  heap_base_r  <= pwdata;
        REG_HEAP_LIMIT: heap_limit_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HEAP_BASE:  prdata = heap_base_r;
      REG_HEAP_LIMIT: prdata = heap_limit_r;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.base_wr = reg_wr && (reg_sel == REG_HEAP_BASE);
  assign cfg.base    = pwdata;
  assign cfg.limit   = heap_limit_r;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_req.action),
    .addr_zero (in_req.block_address == 32'd0),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  ffba_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ----- hdl/ffba_checker.sv -----
// ffba_checker: port-level assertions for first_fit_block_allocator
// depends on ffba_pkg; attached to the top level by the bind below

module ffba_checker
  import ffba_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_res
);

  // an accepted transaction either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor answered");

  // the block goes idle only when it delivers a result
  a_idle_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  // failures carry no addresses or copy span
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ST_OK) |->
      (out_res.data_address == 32'd0 && out_res.copy_source == 32'd0 &&
       out_res.copy_length == 32'd0))
    else $error("failed transaction with nonzero fields");

  // a copy span always comes with a source and a new block
  a_copy_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.copy_length != 32'd0) |->
      (out_res.copy_source != 32'd0 && out_res.status == ST_OK))
    else $error("copy span without source");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
